// ===== rtl/core/ats_pkg.sv =====
// ----------------------------------------------------------------------------
// Tilt angle smoother package
// Shared constants, types and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW       = $clog2(CordicSteps + 1);
  localparam int SqrtSteps   = 24;
  localparam int SqrtCntW    = $clog2(SqrtSteps + 1);
  localparam int QueueDepth  = 2;

  localparam logic signed [31:0] NinetyQ16     = 32'sd5898240;
  localparam logic [15:0]        WeightReset   = 16'd3277;

  // Queued sample passed from the front to the back.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } sample_t;

  // Result of one tilt computation.
  typedef struct packed {
    logic signed [31:0] pitch;
    logic signed [31:0] roll;
  } angles_t;

  function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
    logic signed [31:0] r;
    case (idx)
      5'd0: r = 32'sd2949120;
      5'd1: r = 32'sd1740967;
      5'd2: r = 32'sd919879;
      5'd3: r = 32'sd466945;
      5'd4: r = 32'sd234379;
      5'd5: r = 32'sd117304;
      5'd6: r = 32'sd58666;
      5'd7: r = 32'sd29335;
      5'd8: r = 32'sd14668;
      5'd9: r = 32'sd7334;
      5'd10: r = 32'sd3667;
      5'd11: r = 32'sd1833;
      5'd12: r = 32'sd917;
      5'd13: r = 32'sd458;
      5'd14: r = 32'sd229;
      5'd15: r = 32'sd115;
      5'd16: r = 32'sd57;
      5'd17: r = 32'sd29;
      5'd18: r = 32'sd14;
      5'd19: r = 32'sd7;
      5'd20: r = 32'sd4;
      5'd21: r = 32'sd2;
      5'd22: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/accel_tilt_angle_smoother.sv =====
// ----------------------------------------------------------------------------
// Accelerometer tilt angle smoother
// Pitch and roll from a three-axis sample, smoothed by exponential averages.
// ----------------------------------------------------------------------------
// The bit-serial square root and the CORDIC steps run once per angle, pitch then
// roll. A new sample starts only once the tilt unit is idle, the averaging is
// done and the output register is empty; a two-entry queue holds input
// meanwhile.
// Reset: averages and the seeded flag clear, weight returns to 3277.
`default_nettype none

module accel_tilt_angle_smoother
  import ats_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // accel_x, accel_y, accel_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // pitch_degrees, roll_degrees
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  localparam logic [1:0] StWait = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StAdd  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic               q_full, q_empty, q_pop;
  sample_t            q_head;
  logic               t_busy, t_done;
  angles_t            t_angles;
  logic [1:0]         st_q, st_d;
  logic [15:0]        weight_q;
  logic               seeded_q;
  logic signed [31:0] pavg_q, ravg_q;
  logic signed [32:0] pdiff_q, rdiff_q;
  logic signed [49:0] pprod_q, rprod_q;
  logic signed [31:0] pnew_q, rnew_q;
  logic [31:0]        out_q;
  logic               out_valid_q;
  logic signed [31:0] pround, rround;

  assign s_axis_tready = !q_full;
  assign cfg_ready_o   = 1'b1;

  ats_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (s_axis_tvalid),
    .push_data_i ('{x: s_axis_tdata[15:0], y: s_axis_tdata[31:16],
                    z: s_axis_tdata[47:32]}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_head),
    .empty_o     (q_empty)
  );

  assign q_pop = !q_empty && !t_busy && st_q == StWait && !out_valid_q;

  ats_tilt u_tilt (
    .clk_i, .rst_ni,
    .start_i  (q_pop),
    .sample_i (q_head),
    .busy_o   (t_busy),
    .done_o   (t_done),
    .angles_o (t_angles)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      StWait: if (t_done) st_d = StMul;
      StMul:  st_d = StAdd;
      StAdd:  st_d = StOut;
      StOut:  st_d = StWait;
      default: st_d = StWait;
    endcase
  end

  // Weighted step, rounded, then floor shift by 16.
  always_ff @(posedge clk_i) begin
    if (t_done) begin
      pnew_q  <= t_angles.pitch;
      rnew_q  <= t_angles.roll;
      pdiff_q <= 33'(t_angles.pitch) - 33'(pavg_q);
      rdiff_q <= 33'(t_angles.roll) - 33'(ravg_q);
    end
    if (st_q == StMul) begin
      pprod_q <= 50'(pdiff_q) * $signed({1'b0, weight_q}) + 50'sd32768;
      rprod_q <= 50'(rdiff_q) * $signed({1'b0, weight_q}) + 50'sd32768;
    end
  end

  assign pround = pavg_q + 32'sd128;
  assign rround = ravg_q + 32'sd128;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StWait;
      weight_q    <= WeightReset;
      seeded_q    <= 1'b0;
      pavg_q      <= '0;
      ravg_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) weight_q <= cfg_data_i;
      if (st_q == StAdd) begin
        seeded_q <= 1'b1;
        if (seeded_q) begin
          pavg_q <= pavg_q + 32'(pprod_q >>> 16);
          ravg_q <= ravg_q + 32'(rprod_q >>> 16);
        end else begin
          pavg_q <= pnew_q;
          ravg_q <= rnew_q;
        end
      end
      if (st_q == StOut) begin
        out_valid_q <= 1'b1;
        out_q <= {rround[23:8], pround[23:8]};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_done |-> st_q == StWait)
    else $error("angle result while averaging busy");
  a_seed_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(seeded_q) |-> 1'b0)
    else $error("seeded flag cleared");
  a_out_after_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StAdd |=> st_q == StOut)
    else $error("output step skipped");

endmodule

`default_nettype wire

// ===== rtl/core/ats_queue.sv =====
// ----------------------------------------------------------------------------
// Tilt angle smoother sample queue
// Two-entry register queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_queue
  import ats_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  sample_t      push_data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output sample_t      pop_data_o,
  output logic         empty_o
);

  sample_t     mem_q [QueueDepth];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  assign full_o     = (count_q == 2'(QueueDepth));
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + 1'b1 * (push_i && !full_o);
    rd_ptr_d = rd_ptr_q + 1'b1 * (pop_i && !empty_o);
    count_d  = count_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rst_ni) begin
      assert (!(count_q > 2'(QueueDepth)))
        else $error("queue count out of range");
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |=> count_q != 2'd0)
    else $error("full queue lost its entries");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && empty_o && !push_i) |=> empty_o)
    else $error("pop from empty queue changed state");
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && empty_o) |=> !empty_o)
    else $error("push into empty queue lost");

endmodule

`default_nettype wire

// ===== rtl/core/ats_tilt.sv =====
// ----------------------------------------------------------------------------
// Tilt angle unit
// Iterative square root and vectoring CORDIC, shared by pitch and roll.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_tilt
  import ats_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  sample_t   sample_i,
  output logic      busy_o,
  output logic      done_o,
  output angles_t   angles_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StSqrt = 3'd2;
  localparam logic [2:0] StCord = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]          state_q, state_d;
  logic                pass_q, pass_d;  // 0 pitch, 1 roll
  sample_t             smp_q;
  logic [47:0]         rad_q, rad_d;
  logic [47:0]         res_q, res_d;
  logic [47:0]         bit_q, bit_d;
  logic [SqrtCntW-1:0] scnt_q, scnt_d;
  logic [StepW-1:0]    ccnt_q, ccnt_d;
  logic signed [39:0]  cx_q, cx_d, cy_q, cy_d;
  logic signed [31:0]  ang_q, ang_d;
  logic signed [31:0]  pitch_q, pitch_d;
  logic signed [31:0]  roll_q, roll_d;
  logic signed [15:0]  num, ea, eb;
  logic signed [31:0]  sa, sb;
  logic [31:0]         sumsq;
  logic signed [31:0]  clamped, final_ang;
  logic signed [39:0]  dx, dy;
  logic [47:0]         trial;

  assign num = pass_q ? smp_q.y : smp_q.x;
  assign ea  = pass_q ? smp_q.x : smp_q.y;
  assign eb  = smp_q.z;
  assign sa  = ea * ea;
  assign sb  = eb * eb;
  assign sumsq = 32'(sa) + 32'(sb);
  assign trial = res_q + bit_q;
  assign dx = cy_q >>> ccnt_q;
  assign dy = cx_q >>> ccnt_q;

  always_comb begin
    clamped = ang_q;
    if (ang_q > NinetyQ16) clamped = NinetyQ16;
    if (ang_q < -NinetyQ16) clamped = -NinetyQ16;
    if (num == 16'sd0) final_ang = 32'sd0;
    else if (res_q == 48'd0) final_ang = (num > 0) ? NinetyQ16 : -NinetyQ16;
    else final_ang = clamped;
  end

  always_comb begin
    state_d = state_q; pass_d = pass_q;
    rad_d = rad_q; res_d = res_q; bit_d = bit_q; scnt_d = scnt_q;
    ccnt_d = ccnt_q; cx_d = cx_q; cy_d = cy_q; ang_d = ang_q;
    pitch_d = pitch_q; roll_d = roll_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StSq;
          pass_d  = 1'b0;
        end
      end
      StSq: begin
        rad_d  = {2'b0, sumsq, 14'b0};
        res_d  = 48'd0;
        bit_d  = 48'd1 << 46;
        scnt_d = '0;
        state_d = StSqrt;
      end
      StSqrt: begin
        if (rad_q >= trial) begin
          rad_d = rad_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d  = bit_q >> 2;
        scnt_d = scnt_q + 1'b1;
        if (scnt_q == SqrtCntW'(SqrtSteps - 1)) begin
          state_d = StCord;
          ccnt_d  = '0;
          ang_d   = 32'sd0;
          cx_d    = 40'(res_d);
          cy_d    = 40'(num) <<< 7;
        end
      end
      StCord: begin
        if (ccnt_q == StepW'(CordicSteps)) begin
          if (pass_q) begin
            roll_d  = final_ang;
            state_d = StDone;
          end else begin
            pitch_d = final_ang;
            pass_d  = 1'b1;
            state_d = StSq;
          end
        end else begin
          if (cy_q >= 0) begin
            cx_d = cx_q + dx; cy_d = cy_q - dy;
            ang_d = ang_q + atan_entry(5'(ccnt_q));
          end else begin
            cx_d = cx_q - dx; cy_d = cy_q + dy;
            ang_d = ang_q - atan_entry(5'(ccnt_q));
          end
          ccnt_d = ccnt_q + 1'b1;
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == StIdle) smp_q <= sample_i;
    rad_q <= rad_d; res_q <= res_d; bit_q <= bit_d;
    cx_q <= cx_d; cy_q <= cy_d; ang_q <= ang_d;
    pitch_q <= pitch_d; roll_q <= roll_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pass_q  <= 1'b0;
      scnt_q  <= '0;
      ccnt_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      scnt_q  <= scnt_d;
      ccnt_q  <= ccnt_d;
    end
  end

  assign busy_o   = (state_q != StIdle);
  assign done_o   = (state_q == StDone);
  assign angles_o = '{pitch: pitch_q, roll: roll_q};

  a_roll_after_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> pass_q)
    else $error("done without roll pass");
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_q <= NinetyQ16 && roll_q >= -NinetyQ16 &&
                pitch_q <= NinetyQ16 && pitch_q >= -NinetyQ16))
    else $error("angle out of range");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("start not taken");

endmodule

`default_nettype wire
